// ----- rtl/dgc_pkg.sv -----
// Shared types, AES tables and round helper functions for the disc group codec.
`default_nettype none

package dgc_pkg;

  // Number of AES-128 rounds.
  localparam int NUM_ROUNDS = 10;

  // Configuration register indexes (64-bit registers at byte address 8*i).
  localparam logic [1:0] REG_KEY_HIGH  = 2'd0;
  localparam logic [1:0] REG_KEY_LOW   = 2'd1;
  localparam logic [1:0] REG_DIRECTION = 2'd2;

  // Direction codes.
  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  typedef logic [127:0] blk_t;
  typedef logic [NUM_ROUNDS:0][127:0] round_keys_t;

  // One input transfer.
  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        group_start;
  } in_item_t;

  // One result transfer.
  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic        in_hash_part;
    logic        group_last;
  } out_item_t;

  // Position flags of a block held in the input stage.
  typedef struct packed {
    logic first;
    logic data_start;
    logic iv_capture;
    logic hash;
    logic last;
  } pos_flags_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [0:255] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  localparam logic [7:0] RCON [0:NUM_ROUNDS-1] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte 0 of the state sits in the most significant bits.
  function automatic blk_t sub_bytes(blk_t s);
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = SBOX[s[8*i +: 8]];
    end
    return r;
  endfunction

  function automatic blk_t inv_sub_bytes(blk_t s);
    blk_t r;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = INV_SBOX[s[8*i +: 8]];
    end
    return r;
  endfunction

  function automatic blk_t shift_rows(blk_t s);
    blk_t r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127 - 8*(c*4 + w) -: 8] = s[127 - 8*((((c + w) & 3) * 4) + w) -: 8];
      end
    end
    return r;
  endfunction

  function automatic blk_t inv_shift_rows(blk_t s);
    blk_t r;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        r[127 - 8*(c*4 + w) -: 8] = s[127 - 8*((((c - w + 4) & 3) * 4) + w) -: 8];
      end
    end
    return r;
  endfunction

  function automatic blk_t mix_columns(blk_t s);
    blk_t r;
    logic [7:0] a [4];
    logic [7:0] d [4];
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        a[w] = s[127 - 8*(c*4 + w) -: 8];
        d[w] = xtime(a[w]);
      end
      for (int w = 0; w < 4; w++) begin
        r[127 - 8*(c*4 + w) -: 8] = d[w] ^ d[(w + 1) & 3] ^ a[(w + 1) & 3] ^
                                    a[(w + 2) & 3] ^ a[(w + 3) & 3];
      end
    end
    return r;
  endfunction

  function automatic blk_t inv_mix_columns(blk_t s);
    blk_t r;
    logic [7:0] a [4];
    logic [7:0] m2 [4];
    logic [7:0] m4 [4];
    logic [7:0] m8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        a[w]  = s[127 - 8*(c*4 + w) -: 8];
        m2[w] = xtime(a[w]);
        m4[w] = xtime(m2[w]);
        m8[w] = xtime(m4[w]);
      end
      // Coefficients 14, 11, 13, 9 built from powers of x.
      for (int w = 0; w < 4; w++) begin
        r[127 - 8*(c*4 + w) -: 8] =
            (m8[w] ^ m4[w] ^ m2[w]) ^
            (m8[(w + 1) & 3] ^ m2[(w + 1) & 3] ^ a[(w + 1) & 3]) ^
            (m8[(w + 2) & 3] ^ m4[(w + 2) & 3] ^ a[(w + 2) & 3]) ^
            (m8[(w + 3) & 3] ^ a[(w + 3) & 3]);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/dgc_key_sched.sv -----
// AES-128 key expansion with a registered set of round keys.
`default_nettype none

module dgc_key_sched (
  input  wire                  clk,
  input  wire  [127:0]         cipher_key,
  output dgc_pkg::round_keys_t round_keys
);
  import dgc_pkg::*;

  round_keys_t round_keys_next;

  // Unrolled expansion, one round key per generate step.
  assign round_keys_next[0] = cipher_key;

  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_round
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    assign w0 = round_keys_next[r-1][127:96];
    assign w1 = round_keys_next[r-1][95:64];
    assign w2 = round_keys_next[r-1][63:32];
    assign w3 = round_keys_next[r-1][31:0];
    assign t  = {SBOX[w3[23:16]] ^ RCON[r-1], SBOX[w3[15:8]], SBOX[w3[7:0]],
                 SBOX[w3[31:24]]};
    assign n0 = w0 ^ t;
    assign n1 = w1 ^ n0;
    assign n2 = w2 ^ n1;
    assign n3 = w3 ^ n2;
    assign round_keys_next[r] = {n0, n1, n2, n3};
  end

  // The round keys are registered and follow the key registers in the next cycle.
  always_ff @(posedge clk) begin
    round_keys <= round_keys_next;
  end

endmodule

`default_nettype wire

// ----- rtl/dgc_cipher.sv -----
// Unrolled AES-128 block cipher, both directions, purely combinational.
`default_nettype none

module dgc_cipher (
  input  wire                  decrypt,
  input  wire  [127:0]         block_in,
  input  dgc_pkg::round_keys_t round_keys,
  output logic [127:0]         block_out
);
  import dgc_pkg::*;

  blk_t enc_st [0:NUM_ROUNDS];
  blk_t dec_st [0:NUM_ROUNDS];

  // Forward rounds; the last round skips the column mix.
  assign enc_st[0] = block_in ^ round_keys[0];
  for (genvar r = 1; r <= NUM_ROUNDS; r++) begin : g_enc
    if (r == NUM_ROUNDS) begin : g_last
      assign enc_st[r] = shift_rows(sub_bytes(enc_st[r-1])) ^ round_keys[r];
    end else begin : g_mid
      assign enc_st[r] = mix_columns(shift_rows(sub_bytes(enc_st[r-1]))) ^
                         round_keys[r];
    end
  end

  // Inverse rounds run the round keys backward.
  assign dec_st[0] = block_in ^ round_keys[NUM_ROUNDS];
  for (genvar k = 1; k <= NUM_ROUNDS; k++) begin : g_dec
    blk_t t;
    assign t = inv_sub_bytes(inv_shift_rows(dec_st[k-1])) ^ round_keys[NUM_ROUNDS - k];
    if (k == NUM_ROUNDS) begin : g_last
      assign dec_st[k] = t;
    end else begin : g_mid
      assign dec_st[k] = inv_mix_columns(t);
    end
  end

  assign block_out = decrypt ? dec_st[NUM_ROUNDS] : enc_st[NUM_ROUNDS];

endmodule

`default_nettype wire

// ----- rtl/disc_group_aes_cbc_codec_unit.sv -----
// Top level: AES-128 CBC codec for a disc group with hash and data parts.
// An accepted block waits in the input stage, then moves into the result register when it is free.
// Throughput: one block per cycle unless the result register stalls; the ten unrolled AES
// rounds between input stage and result register set the cycle, and CBC chaining uses it.
// Reset clears the key, direction, block counter, chain and data IV; the
// round key register follows the key registers in the cycle after any write.
`default_nettype none

module disc_group_aes_cbc_codec_unit #(
  parameter int HASH_BLOCKS     = 64,
  parameter int DATA_BLOCKS     = 1984,
  parameter int IV_SOURCE_BLOCK = 61
) (
  input  wire                clk,
  input  wire                rst,
  // Block input channel.
  input  wire                src_valid,
  output logic               src_ready,
  input  dgc_pkg::in_item_t  src,
  // Result channel.
  output logic               dst_valid,
  input  wire                dst_ready,
  output dgc_pkg::out_item_t dst,
  // Configuration port.
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [4:0]         paddr,
  input  wire  [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import dgc_pkg::*;

  localparam int TOTAL = HASH_BLOCKS + DATA_BLOCKS;
  localparam int POS_W = $clog2(TOTAL);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TOTAL - 1);
  localparam logic [POS_W-1:0] HASH_POS = POS_W'(HASH_BLOCKS);
  localparam logic             IV_USED  = (IV_SOURCE_BLOCK < HASH_BLOCKS);
  localparam logic [POS_W-1:0] IV_POS   = IV_USED ? POS_W'(IV_SOURCE_BLOCK) : '0;

  // Configuration registers.
  logic [63:0] key_high, key_low;
  logic        direction;
  logic        cfg_write;

  // Group state.
  logic [POS_W-1:0] block_index, block_index_next, pos;
  logic [127:0]     chain, data_iv;

  // Input stage.
  logic       s1_valid;
  logic [127:0] s1_block;
  pos_flags_t s1_flags;
  logic       out_free, s1_move, src_take;

  // Datapath.
  round_keys_t round_keys;
  logic [127:0] iv, cipher_in, cipher_out, result, ciphertext;

  // APB register file.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high  <= '0;
      key_low   <= '0;
      direction <= DIR_ENCRYPT;
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        REG_KEY_HIGH:  key_high  <= pwdata;
        REG_KEY_LOW:   key_low   <= pwdata;
        REG_DIRECTION: direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_KEY_HIGH:  prdata = key_high;
      REG_KEY_LOW:   prdata = key_low;
      REG_DIRECTION: prdata = {63'd0, direction};
      default:       prdata = '0;
    endcase
  end

  // Handshake: the input stage moves on whenever the result register frees up.
  assign out_free  = !dst_valid || dst_ready;
  assign s1_move   = s1_valid && out_free;
  assign src_ready = !s1_valid || out_free;
  assign src_take  = src_valid && src_ready;

  // Position of the arriving block and the counter's next value.
  assign pos              = src.group_start ? '0 : block_index;
  assign block_index_next = (pos == LAST_POS) ? '0 : pos + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_index <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (src_take) begin
        block_index <= block_index_next;
      end
      if (src_ready) begin
        s1_valid <= src_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      s1_block            <= {src.block_high, src.block_low};
      s1_flags.first      <= (pos == '0);
      s1_flags.data_start <= (pos == HASH_POS);
      s1_flags.iv_capture <= IV_USED && (pos == IV_POS);
      s1_flags.hash       <= (pos < HASH_POS);
      s1_flags.last       <= (pos == LAST_POS);
    end
  end

  // Chaining value for the block in the input stage.
  always_comb begin
    priority if (s1_flags.first) begin
      iv = '0;
    end else if (s1_flags.data_start) begin
      iv = data_iv;
    end else begin
      iv = chain;
    end
  end

  assign cipher_in  = (direction == DIR_DECRYPT) ? s1_block : s1_block ^ iv;
  assign result     = (direction == DIR_DECRYPT) ? cipher_out ^ iv : cipher_out;
  assign ciphertext = (direction == DIR_DECRYPT) ? s1_block : cipher_out;

  dgc_key_sched u_key_sched (
    .clk        (clk),
    .cipher_key ({key_high, key_low}),
    .round_keys (round_keys)
  );

  dgc_cipher u_cipher (
    .decrypt    (direction),
    .block_in   (cipher_in),
    .round_keys (round_keys),
    .block_out  (cipher_out)
  );

  // Chain and data IV follow the ciphertext side in both directions.
  always_ff @(posedge clk) begin
    if (rst) begin
      chain   <= '0;
      data_iv <= '0;
    end else if (s1_move) begin
      chain <= ciphertext;
      if (s1_flags.iv_capture) begin
        data_iv <= ciphertext;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (out_free) begin
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      dst.result_high  <= result[127:64];
      dst.result_low   <= result[63:0];
      dst.in_hash_part <= s1_flags.hash;
      dst.group_last   <= s1_flags.last;
    end
  end

  // The last block of a group always lies in the data part.
  a_last_not_hash: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst.group_last |-> !dst.in_hash_part)
    else $error("group_last result marked as hash part");

  // The block counter stays inside the group.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    block_index <= LAST_POS)
    else $error("block counter out of range");

  // A stalled block in the input stage is not dropped.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid)
    else $error("input stage lost a block under stall");

  // An accepted block advances the counter unless it wraps or restarts.
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    src_take && !src.group_start && (block_index != LAST_POS)
      |=> block_index == $past(block_index) + 1'b1)
    else $error("block counter did not advance");

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the AES-128 CBC disc group codec.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dgc_pkg::*;

  localparam int GROUP_HASH = 64;
  localparam int GROUP_DATA = 1984;
  localparam int GROUP_TOTAL = GROUP_HASH + GROUP_DATA;
  localparam int IV_BLOCK = 61;
  localparam int SWEEP_LEN = 150;
  localparam int PHASE_LEN = 155;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_ready;
  in_item_t src = '0;
  logic dst_valid;
  logic dst_ready = 1'b0;
  out_item_t dst;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  disc_group_aes_cbc_codec_unit DUT (
    .clk(clk), .rst(rst),
    .src_valid(src_valid), .src_ready(src_ready), .src(src),
    .dst_valid(dst_valid), .dst_ready(dst_ready), .dst(dst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Predictor state: configuration and chaining registers.
  logic [127:0] cipher_key;
  logic cipher_dir;
  logic [127:0] prev_cipher;
  logic [127:0] data_iv;
  int unsigned next_pos;

  out_item_t expected_blocks[$];
  int unsigned fail_count = 0;
  int unsigned sent_count = 0;
  int unsigned recv_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned decrypt_blocks = 0;
  int unsigned restart_count = 0;
  bit rx_stall_enable = 1'b1;

  function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  // State bytes are kept as byte 0 at index 0.
  typedef logic [7:0] state_bytes_t [16];

  function automatic void unpack_state(logic [127:0] v, output state_bytes_t s);
    for (int i = 0; i < 16; i++) s[i] = v[127 - 8*i -: 8];
  endfunction

  function automatic logic [127:0] pack_state(state_bytes_t s);
    logic [127:0] v;
    for (int i = 0; i < 16; i++) v[127 - 8*i -: 8] = s[i];
    return v;
  endfunction

  // Builds all eleven round keys from the current key.
  function automatic void build_schedule(logic [127:0] k, output logic [7:0] rk [176]);
    logic [7:0] t [4];
    logic [7:0] f;
    for (int i = 0; i < 16; i++) rk[i] = k[127 - 8*i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) t[j] = rk[4*(i-1) + j];
      if ((i & 3) == 0) begin
        f = t[0];
        t[0] = SBOX[t[1]] ^ RCON[i/4 - 1];
        t[1] = SBOX[t[2]];
        t[2] = SBOX[t[3]];
        t[3] = SBOX[f];
      end
      for (int j = 0; j < 4; j++) rk[4*i + j] = rk[4*(i-4) + j] ^ t[j];
    end
  endfunction

  function automatic void rows_shift(ref state_bytes_t s, input bit inv);
    state_bytes_t t;
    int src_col;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src_col = inv ? ((c - r + 4) & 3) : ((c + r) & 3);
        t[c*4 + r] = s[src_col*4 + r];
      end
    end
    s = t;
  endfunction

  function automatic void columns_mix(ref state_bytes_t s, input bit inv);
    logic [7:0] a [4];
    logic [7:0] m0, m1, m2, m3;
    m0 = inv ? 8'd14 : 8'd2;
    m1 = inv ? 8'd11 : 8'd3;
    m2 = inv ? 8'd13 : 8'd1;
    m3 = inv ? 8'd9 : 8'd1;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = s[4*c + r];
      for (int r = 0; r < 4; r++) begin
        s[4*c + r] = gf_mul(a[r], m0) ^ gf_mul(a[(r+1) & 3], m1) ^
                     gf_mul(a[(r+2) & 3], m2) ^ gf_mul(a[(r+3) & 3], m3);
      end
    end
  endfunction

  // Runs one AES-128 block operation in the given direction.
  function automatic logic [127:0] aes_block(logic [127:0] din, logic [127:0] k, logic dec);
    logic [7:0] rk [176];
    state_bytes_t s;
    build_schedule(k, rk);
    unpack_state(din, s);
    if (dec == DIR_DECRYPT) begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[160 + i];
      for (int r = 9; r >= 0; r--) begin
        rows_shift(s, 1'b1);
        for (int i = 0; i < 16; i++) s[i] = INV_SBOX[s[i]];
        for (int i = 0; i < 16; i++) s[i] ^= rk[16*r + i];
        if (r != 0) columns_mix(s, 1'b1);
      end
    end else begin
      for (int i = 0; i < 16; i++) s[i] ^= rk[i];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) s[i] = SBOX[s[i]];
        rows_shift(s, 1'b0);
        if (r != 10) columns_mix(s, 1'b0);
        for (int i = 0; i < 16; i++) s[i] ^= rk[16*r + i];
      end
    end
    return pack_state(s);
  endfunction

  // Computes the result of one accepted block and advances the chain.
  function automatic out_item_t codec_block(in_item_t item);
    out_item_t res;
    int unsigned pos;
    logic [127:0] iv, cipher, outv;
    pos = item.group_start ? 0 : next_pos;
    if (pos >= GROUP_TOTAL) pos = 0;
    if (pos == 0) iv = '0;
    else if (pos == GROUP_HASH) iv = data_iv;
    else iv = prev_cipher;
    if (cipher_dir == DIR_DECRYPT) begin
      cipher = {item.block_high, item.block_low};
      outv = aes_block(cipher, cipher_key, DIR_DECRYPT) ^ iv;
    end else begin
      outv = aes_block({item.block_high, item.block_low} ^ iv, cipher_key, DIR_ENCRYPT);
      cipher = outv;
    end
    prev_cipher = cipher;
    if (pos == IV_BLOCK && pos < GROUP_HASH) data_iv = cipher;
    res.result_high = outv[127:64];
    res.result_low = outv[63:0];
    res.in_hash_part = (pos < GROUP_HASH);
    res.group_last = (pos == GROUP_TOTAL - 1);
    next_pos = (pos + 1 >= GROUP_TOTAL) ? 0 : pos + 1;
    return res;
  endfunction

  // Random gap: mostly short, sometimes long, often none.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one block and records the expected result; valid stays up when
  // the next block follows with no gap.
  task automatic send_block(input in_item_t item);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src <= item;
    src_valid <= 1'b1;
    expected_blocks.push_back(codec_block(item));
    if (cipher_dir == DIR_DECRYPT) decrypt_blocks++;
    if (item.group_start) restart_count++;
    do @(posedge clk); while (!src_ready);
    sent_count++;
  endtask

  // Drops valid and waits until all results are back, plus drain time.
  task automatic drain();
    src_valid <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write over the configuration port; block must be idle.
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_KEY_HIGH: cipher_key[127:64] = value;
      REG_KEY_LOW: cipher_key[63:0] = value;
      REG_DIRECTION: cipher_dir = value[0];
      default: ;
    endcase
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(input logic [127:0] k, input logic dir);
    write_reg(REG_KEY_HIGH, k[127:64]);
    write_reg(REG_KEY_LOW, k[63:0]);
    write_reg(REG_DIRECTION, {63'd0, dir});
  endtask

  function automatic in_item_t rand_block(bit restart);
    in_item_t it;
    it.block_high = {$urandom, $urandom};
    it.block_low = {$urandom, $urandom};
    it.group_start = restart;
    return it;
  endfunction

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst && dst_valid && dst_ready) begin
      recv_count++;
      if (expected_blocks.size() == 0) begin
        $error("result transfer with no expectation: %h", dst);
        fail_count++;
      end else begin
        exp_item = expected_blocks.pop_front();
        if (dst.result_high !== exp_item.result_high) begin
          $error("result_high expected %h actual %h", exp_item.result_high, dst.result_high);
          fail_count++;
        end
        if (dst.result_low !== exp_item.result_low) begin
          $error("result_low expected %h actual %h", exp_item.result_low, dst.result_low);
          fail_count++;
        end
        if (dst.in_hash_part !== exp_item.in_hash_part) begin
          $error("in_hash_part expected %b actual %b", exp_item.in_hash_part,
                 dst.in_hash_part);
          fail_count++;
        end
        if (dst.group_last !== exp_item.group_last) begin
          $error("group_last expected %b actual %b", exp_item.group_last, dst.group_last);
          fail_count++;
        end
      end
    end
  end

  // Receiver back-pressure with runs of random stalls and free stretches.
  always @(posedge clk) begin
    if (rst || !rx_stall_enable) begin
      dst_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 8) begin
      dst_ready <= 1'b0;
    end else if (!dst_ready && $urandom_range(0, 99) < 70) begin
      dst_ready <= 1'b0;
    end else begin
      dst_ready <= 1'b1;
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((src_valid && src_ready) || (dst_valid && dst_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed stimulus table: block value and group start flag.
  typedef struct {
    logic [127:0] blk;
    logic restart;
  } stim_row_t;

  initial begin
    stim_row_t dir_rows [$];
    logic [127:0] fips_key;
    out_item_t known;
    in_item_t it;
    bit restart;

    cipher_key = '0;
    cipher_dir = DIR_ENCRYPT;
    prev_cipher = '0;
    data_iv = '0;
    next_pos = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Known answer from the AES standard: block 0 with zero IV is plain ECB.
    fips_key = 128'h000102030405060708090a0b0c0d0e0f;
    set_config(fips_key, DIR_ENCRYPT);
    known.result_high = 64'h69c4e0d86a7b0430;
    known.result_low = 64'hd8cdb78070b4c55a;
    known.in_hash_part = 1'b1;
    known.group_last = 1'b0;
    it.block_high = 64'h0011223344556677;
    it.block_low = 64'h8899aabbccddeeff;
    it.group_start = 1'b1;
    src <= it;
    src_valid <= 1'b1;
    void'(codec_block(it));
    expected_blocks.push_back(known);
    restart_count++;
    do @(posedge clk); while (!src_ready);
    sent_count++;
    drain();

    // Extremes of the block fields and of the key, with and without restarts.
    set_config({128{1'b1}}, DIR_ENCRYPT);
    dir_rows.push_back('{128'h0, 1'b1});
    dir_rows.push_back('{{128{1'b1}}, 1'b0});
    dir_rows.push_back('{128'h8000_0000_0000_0000_0000_0000_0000_0001, 1'b0});
    dir_rows.push_back('{128'h5555_aaaa_5555_aaaa_aaaa_5555_aaaa_5555, 1'b1});
    dir_rows.push_back('{{128{1'b1}}, 1'b1});
    dir_rows.push_back('{128'h0, 1'b0});
    foreach (dir_rows[i]) begin
      it.block_high = dir_rows[i].blk[127:64];
      it.block_low = dir_rows[i].blk[63:0];
      it.group_start = dir_rows[i].restart;
      send_block(it);
    end
    drain();

    // Decrypt direction with an all-zero key, restart mid-group included.
    set_config('0, DIR_DECRYPT);
    for (int i = 0; i < 8; i++) send_block(rand_block(i == 0 || i == 5));
    drain();

    // Sender holds off until all results are back, then resumes.
    send_block(rand_block(1'b0));
    drain();

    // Group sweeps past the IV capture and into the data part, both directions.
    for (int pass = 0; pass < 2; pass++) begin
      set_config({$urandom, $urandom, $urandom, $urandom}, pass[0]);
      it = rand_block(1'b1);
      send_block(it);
      for (int i = 1; i < SWEEP_LEN; i++) send_block(rand_block(1'b0));
      drain();
    end

    // Random part: short groups cut by restarts; rarely a restart mid-group.
    for (int phase = 0; phase < 6; phase++) begin
      set_config({$urandom, $urandom, $urandom, $urandom}, 1'($urandom_range(0, 1)));
      rx_stall_enable = (phase != 2);
      for (int i = 0; i < PHASE_LEN; i++) begin
        restart = ($urandom_range(0, 99) < 3) || i == 0;
        send_block(rand_block(restart));
      end
      drain();
    end
    rx_stall_enable = 1'b1;

    $display("Covered %0d blocks (%0d decrypted), %0d group restarts, and hash-to-data",
             sent_count, decrypt_blocks, restart_count);
    $display("part sweeps with IV capture in both directions under random stalls.");
    if (fail_count == 0 && expected_blocks.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/dgc_pkg.sv
rtl/dgc_key_sched.sv
rtl/dgc_cipher.sv
rtl/disc_group_aes_cbc_codec_unit.sv
bench/testbench.sv
